[src/gsp_pkg.sv]
`default_nettype none

package gsp_pkg;

  // func codes of an input beat
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RUN  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_REACHED     = 2'd1;
  localparam logic [1:0] STATUS_UNREACHABLE = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  CFG_THRESHOLD = 2'd0;
  localparam logic [1:0]  CFG_COLUMNS   = 2'd1;
  localparam logic [1:0]  CFG_ROWS      = 2'd2;

  localparam logic [7:0] THRESHOLD_RESET = 8'd127;
  localparam logic [6:0] COLUMNS_RESET   = 7'd64;
  localparam logic [6:0] ROWS_RESET      = 7'd64;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] cell_index;
    logic [7:0]  pixel;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] distance;
    logic        reached;
    logic [11:0] parent_index;
    logic        has_parent;
    logic        was_visited;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_RESP,
    ST_RUN_INIT,
    ST_SWEEP,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_NB_RD,
    ST_NB_WR,
    ST_MARK
  } state_t;

  // read address source of both stores
  typedef enum logic [1:0] {
    RD_RESP,
    RD_SCAN,
    RD_NB
  } rd_sel_t;

  // write source of the search store
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SWEEP,
    WR_RELAX,
    WR_MARK
  } wr_sel_t;

  typedef struct packed {
    logic       accept;
    logic       run_init;
    logic       seed;
    rd_sel_t    rd_sel;
    wr_sel_t    wr_sel;
    logic       scan;
    logic       clr_found;
    logic [1:0] nb_sel;
    logic       fin;
    logic [1:0] fin_status;
    logic       resp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic scan_last;
    logic found;
    logic cur_is_last;
    logic nb_ok;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

[src/grid_shortest_path_engine_unit.sv]
`default_nettype none
// Load and read beats: the store is read in ST_RD and the result registered from ST_RESP;
// no new beat is taken before that. Run beat: a setup state, a clearing sweep of all
// MAX_ROWS*MAX_COLS cells, then per settled cell a scan of the cells in use (one cell
// a cycle) plus selection and neighbor updates. A stalled result holds the block.
// Reset: synchronous; a clearing pass over all MAX_ROWS*MAX_COLS cells follows,
// during which in_stall stays high. Config writes are taken at any time.

module grid_shortest_path_engine_unit
  import gsp_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_beat_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_beat_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  gsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gsp_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[src/gsp_ram.sv]
`default_nettype none

module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/gsp_ctrl.sv]
`default_nettype none

module gsp_ctrl
  import gsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_func,
  output logic            in_stall,
  input  wire ctrl_sts_t  sts,
  output ctrl_cmd_t       cmd
);

  state_t     state, state_next;
  logic [1:0] nb, nb_next;

  // state and neighbor counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      nb    <= 2'd0;
    end else begin
      state <= state_next;
      nb    <= nb_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    nb_next    = nb;
    in_stall   = 1'b1;
    cmd        = '0;
    cmd.rd_sel = RD_RESP;
    cmd.wr_sel = WR_NONE;
    cmd.nb_sel = nb;
    case (state)
      ST_CLEAR: begin
        cmd.wr_sel = WR_SWEEP;
        if (sts.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (in_func == FUNC_RUN) ? ST_RUN_INIT : ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_RUN_INIT: begin
        cmd.run_init = 1'b1;
        state_next   = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.wr_sel    = WR_SWEEP;
        cmd.seed      = 1'b1;
        cmd.clr_found = 1'b1;
        if (sts.sweep_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_sel = RD_SCAN;
        cmd.scan   = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        // last scan beat is compared this cycle
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts.found) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = STATUS_UNREACHABLE;
          state_next     = ST_RD;
        end else begin
          nb_next    = 2'd0;
          state_next = ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        cmd.rd_sel = RD_NB;
        if (sts.nb_ok) begin
          state_next = ST_NB_WR;
        end else if (nb == 2'd3) begin
          state_next = ST_MARK;
        end else begin
          nb_next = nb + 2'd1;
        end
      end
      ST_NB_WR: begin
        cmd.rd_sel = RD_NB;
        cmd.wr_sel = WR_RELAX;
        if (nb == 2'd3) begin
          state_next = ST_MARK;
        end else begin
          nb_next    = nb + 2'd1;
          state_next = ST_NB_RD;
        end
      end
      ST_MARK: begin
        cmd.wr_sel    = WR_MARK;
        cmd.clr_found = 1'b1;
        if (sts.cur_is_last) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = STATUS_REACHED;
          state_next     = ST_RD;
        end else begin
          state_next = ST_SCAN;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/gsp_dp.sv]
`default_nettype none

module gsp_dp
  import gsp_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire in_beat_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire ctrl_cmd_t            cmd,
  output ctrl_sts_t                 sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_beat_t                 out_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int RLW   = $clog2(MAX_ROWS + 1);
  localparam int PW    = CLW + RLW;
  localparam int EW    = (AW > 12) ? AW : 12;
  // search record: visited, parent valid, reached, parent, distance
  localparam int RECW  = 2 * AW + 3;
  localparam int B_RCH = 2 * AW;
  localparam int B_PV  = 2 * AW + 1;
  localparam int B_VIS = 2 * AW + 2;

  // configuration
  logic [7:0] thr;
  logic [6:0] cols_cfg, rows_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= THRESHOLD_RESET;
      cols_cfg <= COLUMNS_RESET;
      rows_cfg <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr      <= cfg_data;
        CFG_COLUMNS:   cols_cfg <= cfg_data[6:0];
        CFG_ROWS:      rows_cfg <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // grid size clamped to 1..MAX
  logic [CLW-1:0] cols_eff;
  logic [RLW-1:0] rows_eff;

  always_comb begin
    if (cols_cfg == 7'd0) begin
      cols_eff = CLW'(1);
    end else if (int'(cols_cfg) > MAX_COLS) begin
      cols_eff = CLW'(MAX_COLS);
    end else begin
      cols_eff = CLW'(cols_cfg);
    end
    if (rows_cfg == 7'd0) begin
      rows_eff = RLW'(1);
    end else if (int'(rows_cfg) > MAX_ROWS) begin
      rows_eff = RLW'(MAX_ROWS);
    end else begin
      rows_eff = RLW'(rows_cfg);
    end
  end

  // target cell, latched at run start
  logic [AW-1:0] last;
  logic [PW-1:0] prod;

  assign prod = PW'(cols_eff) * PW'(rows_eff);

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      last <= AW'(prod - PW'(1));
    end
  end

  // accepted beat decode
  logic          in_range;
  logic [AW-1:0] in_addr;

  assign in_range = int'(in_data.cell_index) < CELLS;
  assign in_addr  = AW'(in_data.cell_index);

  // response address, status and zero flag
  logic [AW-1:0] resp_addr;
  logic [1:0]    resp_status;
  logic          resp_zero;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      resp_addr   <= in_addr;
      resp_status <= STATUS_OK;
      resp_zero   <= (in_data.func == FUNC_NONE) || !in_range;
    end else if (cmd.fin) begin
      resp_addr   <= last;
      resp_status <= cmd.fin_status;
      resp_zero   <= 1'b0;
    end
  end

  // clearing sweep counter
  logic [AW-1:0] sweep_cnt;

  always_ff @(posedge clk) begin
    if (rst || cmd.wr_sel != WR_SWEEP) begin
      sweep_cnt <= '0;
    end else begin
      sweep_cnt <= sweep_cnt + AW'(1);
    end
  end

  // scan address with row and column tracking
  logic [AW-1:0]  sc_idx, d_idx;
  logic [CLW-1:0] sc_col, d_col;
  logic [RLW-1:0] sc_row, d_row;
  logic           scan_vld;

  always_ff @(posedge clk) begin
    if (rst || !cmd.scan) begin
      sc_idx <= '0;
      sc_col <= '0;
      sc_row <= '0;
    end else begin
      sc_idx <= sc_idx + AW'(1);
      if (sc_col + CLW'(1) == cols_eff) begin
        sc_col <= '0;
        sc_row <= sc_row + RLW'(1);
      end else begin
        sc_col <= sc_col + CLW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= cmd.scan;
    end
    d_idx <= sc_idx;
    d_col <= sc_col;
    d_row <= sc_row;
  end

  // stores
  logic            free_we, free_wdata, free_rdata;
  logic [AW-1:0]   rd_addr, rec_waddr, nb_addr;
  logic            rec_we;
  logic [RECW-1:0] rec_wdata, rec_rdata;

  gsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (in_addr),
    .wdata (free_wdata),
    .raddr (rd_addr),
    .rdata (free_rdata)
  );

  gsp_ram #(.WIDTH(RECW), .DEPTH(CELLS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rd_addr),
    .rdata (rec_rdata)
  );

  assign free_we    = cmd.accept && (in_data.func == FUNC_LOAD) && in_range;
  assign free_wdata = in_data.pixel < thr;

  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN: rd_addr = sc_idx;
      RD_NB:   rd_addr = nb_addr;
      default: rd_addr = resp_addr;
    endcase
  end

  // running minimum over one scan
  logic            found;
  logic [AW-1:0]   cur_idx;
  logic [CLW-1:0]  cur_col;
  logic [RLW-1:0]  cur_row;
  logic [RECW-1:0] cur_rec;
  logic            cand;

  assign cand = scan_vld && !rec_rdata[B_VIS] && free_rdata && rec_rdata[B_RCH] &&
                (!found || rec_rdata[AW-1:0] < cur_rec[AW-1:0]);

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_found) begin
      found <= 1'b0;
    end else if (cand) begin
      found <= 1'b1;
    end
    if (cand) begin
      cur_idx <= d_idx;
      cur_col <= d_col;
      cur_row <= d_row;
      cur_rec <= rec_rdata;
    end
  end

  // neighbor address and grid edge check
  logic          nb_ok;
  logic [AW-1:0] nd;
  logic          relax_ok;

  always_comb begin
    case (cmd.nb_sel)
      2'd0: begin
        nb_ok   = (cur_col + CLW'(1)) < cols_eff;
        nb_addr = cur_idx + AW'(1);
      end
      2'd1: begin
        nb_ok   = cur_col != '0;
        nb_addr = cur_idx - AW'(1);
      end
      2'd2: begin
        nb_ok   = cur_row != '0;
        nb_addr = cur_idx - AW'(cols_eff);
      end
      default: begin
        nb_ok   = (cur_row + RLW'(1)) < rows_eff;
        nb_addr = cur_idx + AW'(cols_eff);
      end
    endcase
  end

  assign nd       = cur_rec[AW-1:0] + AW'(1);
  assign relax_ok = free_rdata && (!rec_rdata[B_RCH] || nd < rec_rdata[AW-1:0]);

  // search store write
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = sweep_cnt;
    rec_wdata = '0;
    case (cmd.wr_sel)
      WR_SWEEP: begin
        rec_we = 1'b1;
        rec_wdata[B_RCH] = cmd.seed && (sweep_cnt == '0);
      end
      WR_RELAX: begin
        rec_we    = relax_ok;
        rec_waddr = nb_addr;
        rec_wdata = {rec_rdata[B_VIS], 1'b1, 1'b1, cur_idx, nd};
      end
      WR_MARK: begin
        rec_we    = 1'b1;
        rec_waddr = cur_idx;
        rec_wdata = cur_rec;
        rec_wdata[B_VIS] = 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  logic [EW-1:0] dist_e, par_e;
  out_beat_t     beat;

  assign dist_e = EW'(rec_rdata[AW-1:0]);
  assign par_e  = EW'(rec_rdata[2*AW-1:AW]);

  always_comb begin
    beat        = '0;
    beat.status = resp_status;
    if (!resp_zero) begin
      if (rec_rdata[B_RCH]) begin
        beat.distance = (dist_e > EW'(4095)) ? 12'hFFF : dist_e[11:0];
        beat.reached  = 1'b1;
      end
      if (rec_rdata[B_PV]) begin
        beat.parent_index = par_e[11:0];
        beat.has_parent   = 1'b1;
      end
      beat.was_visited = rec_rdata[B_VIS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.resp_load) begin
      out_data <= beat;
    end
  end

  // status to controller
  always_comb begin
    sts.sweep_done  = sweep_cnt == AW'(CELLS - 1);
    sts.scan_last   = sc_idx == last;
    sts.found       = found;
    sts.cur_is_last = cur_idx == last;
    sts.nb_ok       = nb_ok;
    sts.out_free    = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsp_pkg::*;

  localparam int ROWS_MAX  = 64;
  localparam int COLS_MAX  = 64;
  localparam int CELLS     = ROWS_MAX * COLS_MAX;
  localparam int ITEM_GOAL = 1550;
  localparam int unsigned UNREACHED = 32'hFFFF_FFFF;

  // grid model: free bits, search store and the beats it still owes
  class GridPathScoreboard;
    bit                free_bit [CELLS];
    bit                loaded   [CELLS];
    int unsigned       path_len [CELLS];
    int unsigned       parent   [CELLS];
    bit                has_par  [CELLS];
    bit                settled  [CELLS];
    logic [7:0]        threshold;
    logic [6:0]        columns;
    logic [6:0]        rows;
    out_beat_t         owed_beats [$];
    int                errors;

    function new();
      threshold = THRESHOLD_RESET;
      columns   = COLUMNS_RESET;
      rows      = ROWS_RESET;
      errors    = 0;
      foreach (free_bit[i]) begin
        free_bit[i] = 1'b0;
        loaded[i]   = 1'b0;
      end
      clear_search();
    endfunction

    function void clear_search();
      foreach (path_len[i]) begin
        path_len[i] = UNREACHED;
        parent[i]   = 0;
        has_par[i]  = 1'b0;
        settled[i]  = 1'b0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_THRESHOLD: threshold = val;
        CFG_COLUMNS:   columns   = val[6:0];
        CFG_ROWS:      rows      = val[6:0];
        default: ;
      endcase
    endfunction

    function int clamp_dim(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int eff_cols();
      return clamp_dim(columns, COLS_MAX);
    endfunction

    function int eff_rows();
      return clamp_dim(rows, ROWS_MAX);
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    // append one expected result beat
    function void queue_beat(out_beat_t b);
      owed_beats = {owed_beats, b};
    endfunction

    function void relax(int from, int to);
      int unsigned nd;
      nd = path_len[from] + 1;
      if (free_bit[to] && nd < path_len[to]) begin
        path_len[to] = nd;
        parent[to]   = from;
        has_par[to]  = 1'b1;
      end
    endfunction

    // unit-weight Dijkstra from cell 0 to the last cell in use
    function logic [1:0] settle_grid(output int target);
      int cols, rws, n, cur, r, c;
      int unsigned best;
      bit found;
      cols   = eff_cols();
      rws    = eff_rows();
      n      = cols * rws;
      target = n - 1;
      clear_search();
      path_len[0] = 0;
      forever begin
        found = 1'b0;
        best  = UNREACHED;
        cur   = 0;
        for (int i = 0; i < n; i++) begin
          if (!settled[i] && free_bit[i] && path_len[i] < best) begin
            best  = path_len[i];
            cur   = i;
            found = 1'b1;
          end
        end
        if (!found) return STATUS_UNREACHABLE;
        r = cur / cols;
        c = cur % cols;
        if (c + 1 < cols) relax(cur, cur + 1);
        if (c > 0) relax(cur, cur - 1);
        if (r > 0) relax(cur, cur - cols);
        if (r + 1 < rws) relax(cur, cur + cols);
        settled[cur] = 1'b1;
        if (cur == target) return STATUS_REACHED;
      end
    endfunction

    function out_beat_t cell_view(int idx, logic [1:0] st);
      out_beat_t b;
      b = '0;
      b.status = st;
      if (path_len[idx] != UNREACHED) begin
        b.distance = (path_len[idx] > 4095) ? 12'd4095 : path_len[idx][11:0];
        b.reached  = 1'b1;
      end
      if (has_par[idx]) begin
        b.parent_index = parent[idx][11:0];
        b.has_parent   = 1'b1;
      end
      b.was_visited = settled[idx];
      return b;
    endfunction

    function void note_input(in_beat_t b);
      int target;
      logic [1:0] st;
      case (b.func)
        FUNC_LOAD: begin
          free_bit[b.cell_index] = (b.pixel < threshold);
          loaded[b.cell_index]   = 1'b1;
          queue_beat(cell_view(b.cell_index, STATUS_OK));
        end
        FUNC_RUN: begin
          st = settle_grid(target);
          queue_beat(cell_view(target, st));
        end
        FUNC_READ: queue_beat(cell_view(b.cell_index, STATUS_OK));
        default:   queue_beat('0);
      endcase
    endfunction

    function void report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (owed_beats.size() == 0) begin
        report("unexpected result beat", got, 0);
        return;
      end
      want = owed_beats.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.distance !== want.distance) report("distance", got.distance, want.distance);
      if (got.reached !== want.reached) report("reached", got.reached, want.reached);
      if (got.parent_index !== want.parent_index)
        report("parent_index", got.parent_index, want.parent_index);
      if (got.has_parent !== want.has_parent)
        report("has_parent", got.has_parent, want.has_parent);
      if (got.was_visited !== want.was_visited)
        report("was_visited", got.was_visited, want.was_visited);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  GridPathScoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int items      = 0;

  grid_shortest_path_engine_unit #(.MAX_ROWS(ROWS_MAX), .MAX_COLS(COLS_MAX)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result side: check accepted beats, stall in modes of random length
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(5, 80);
      end
      stall_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // one input beat; valid stays up through a burst
  task automatic send(logic [1:0] f, int idx, int pix);
    in_beat_t b;
    b.func       = f;
    b.cell_index = idx[11:0];
    b.pixel      = pix[7:0];
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    items++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, int val);
    cfg_index <= idx;
    cfg_data  <= val[7:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val[7:0]);
    @(posedge clk);
  endtask

  // pixel on the chosen side of the current threshold
  function automatic int pick_pixel(bit want_free);
    int thr;
    thr = sb.threshold;
    if (want_free && thr > 0) return $urandom_range(0, thr - 1);
    if (thr == 0) return $urandom_range(0, 255);
    return $urandom_range(thr, 255);
  endfunction

  initial begin
    int n, fr, op;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single cell grid from zero sizes; searches touch loaded cells only
    cfg_write(CFG_COLUMNS, 0);
    cfg_write(CFG_ROWS, 0);
    send(FUNC_READ, 0, 0);
    send(FUNC_NONE, 4095, 255);
    send(FUNC_LOAD, 0, 255);
    send(FUNC_RUN, 4095, 255);        // blocked start
    send(FUNC_LOAD, 0, 127);          // at threshold: blocked
    send(FUNC_RUN, 0, 0);
    send(FUNC_LOAD, 0, 126);
    send(FUNC_RUN, 0, 0);
    drain();

    // 2x2 grid: start free, all neighbors blocked
    cfg_write(CFG_COLUMNS, 2);
    cfg_write(CFG_ROWS, 2);
    send(FUNC_LOAD, 0, 0);
    for (int i = 1; i < 4; i++) send(FUNC_LOAD, i, 255);
    send(FUNC_RUN, 0, 0);
    send(FUNC_READ, 0, 0);
    send(FUNC_READ, 1, 0);
    send(FUNC_READ, 4095, 0);
    drain();

    // threshold extremes
    cfg_write(CFG_THRESHOLD, 0);
    send(FUNC_LOAD, 0, 0);
    send(FUNC_RUN, 0, 0);
    drain();
    cfg_write(CFG_THRESHOLD, 255);
    send(FUNC_LOAD, 0, 255);
    send(FUNC_LOAD, 0, 254);
    drain();

    // oversized columns saturate: one free row of 64
    cfg_write(CFG_COLUMNS, 127);
    cfg_write(CFG_ROWS, 1);
    for (int i = 0; i < COLS_MAX; i++) send(FUNC_LOAD, i, $urandom_range(0, 254));
    send(FUNC_RUN, 0, 0);
    send(FUNC_READ, 63, 0);
    send(FUNC_READ, 32, 0);
    drain();
    // oversized rows saturate: the same cells as one column of 64
    cfg_write(CFG_COLUMNS, 1);
    cfg_write(CFG_ROWS, 127);
    send(FUNC_RUN, 0, 0);
    drain();

    // random phases: fresh maze per setting, then mixed traffic
    while (items < ITEM_GOAL) begin
      case ($urandom_range(0, 5))
        0:       cfg_write(CFG_THRESHOLD, ($urandom_range(0, 1) != 0) ? 0 : 255);
        default: cfg_write(CFG_THRESHOLD, $urandom_range(1, 254));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        cfg_write(CFG_COLUMNS, ($urandom_range(0, 1) != 0) ? 64 : $urandom_range(65, 127));
        cfg_write(CFG_ROWS, $urandom_range(0, 2));
      end else begin
        cfg_write(CFG_COLUMNS, $urandom_range(0, 8));
        cfg_write(CFG_ROWS, $urandom_range(0, 8));
      end
      n  = sb.eff_cols() * sb.eff_rows();
      fr = $urandom_range(55, 90);
      for (int i = 0; i < n; i++)
        send(FUNC_LOAD, i, pick_pixel(i == 0 ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 99) < fr)));
      send(FUNC_RUN, $urandom_range(0, 4095), $urandom_range(0, 255));
      repeat ($urandom_range(10, 40)) begin
        op = $urandom_range(0, 99);
        if (op < 40)
          send(FUNC_READ, $urandom_range(0, n - 1), $urandom_range(0, 255));
        else if (op < 55)
          send(FUNC_READ, $urandom_range(0, 4095), $urandom_range(0, 255));
        else if (op < 78)
          send(FUNC_LOAD, $urandom_range(0, n - 1), $urandom_range(0, 255));
        else if (op < 83)
          send(FUNC_LOAD, $urandom_range(0, 4095), $urandom_range(0, 255));
        else if (op < 94)
          send(FUNC_RUN, $urandom_range(0, 4095), $urandom_range(0, 255));
        else
          send(FUNC_NONE, $urandom_range(0, 4095), $urandom_range(0, 255));
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("grid_shortest_path_engine_unit verification clean");
    end else begin
      $display("grid_shortest_path_engine_unit verification failed");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #160ms;
    $display("grid_shortest_path_engine_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
src/gsp_pkg.sv
src/gsp_ram.sv
src/gsp_ctrl.sv
src/gsp_dp.sv
src/grid_shortest_path_engine_unit.sv
tb/tb.sv
